// ===== design/tha_pkg.sv =====
// ----------------------------------------------------------------------------
// tha_pkg: shared types and constants for the typed handle id allocator
// Class codes, opcodes, status codes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tha_pkg;

  localparam int NUM_TABLES = 9;

  localparam logic [3:0] C_GENERIC  = 4'd0;
  localparam logic [3:0] C_WIDGET   = 4'd1;
  localparam logic [3:0] C_GADGET   = 4'd2;
  localparam logic [3:0] C_WINDOW   = 4'd3;
  localparam logic [3:0] C_SCREEN   = 4'd4;
  localparam logic [3:0] C_GROUP    = 4'd5;
  localparam logic [3:0] C_ROW      = 4'd6;
  localparam logic [3:0] C_MENUITEM = 4'd7;
  localparam logic [3:0] C_MENU     = 4'd8;
  localparam logic [3:0] C_MSGPORT  = 4'd9;
  localparam logic [3:0] C_MUTEX    = 4'd10;
  localparam logic [3:0] C_MODULE   = 4'd11;
  localparam logic [3:0] C_DISPLAY  = 4'd12;
  localparam logic [3:0] C_MSG      = 4'd13;
  localparam logic [3:0] C_UNDEF    = 4'd15;

  localparam logic [3:0] KIND_PASS = 4'd14;
  localparam logic [3:0] KIND_NONE = 4'd15;

  localparam logic [1:0] OP_ASSIGN = 2'd0;
  localparam logic [1:0] OP_DROP   = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTALLOW = 2'd2;
  localparam logic [1:0] ST_MISS     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_CHECK,
    S_UP_RD,
    S_UP_CHK,
    S_DN_RD,
    S_DN_CHK,
    S_RESP
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ASSIGN,
    CMD_READ_IDX,
    CMD_RES_IMM,
    CMD_CHECK,
    CMD_READ_PTR,
    CMD_UP_DONE,
    CMD_PTR_INC,
    CMD_DN_BOT,
    CMD_DN_HIT,
    CMD_PTR_DEC,
    CMD_OUT
  } cmd_e;

  typedef struct packed {
    cmd_e op;
  } cmd_t;

  typedef struct packed {
    logic assign_go;
    logic need_read;
    logic is_drop;
    logic drop_hit;
    logic rd_occ;
    logic ptr_ge_top;
    logic ptr_le_lf;
    logic out_busy;
  } sts_t;

  function automatic logic [3:0] class_kind(input logic [3:0] c);
    logic [3:0] k;
    case (c)
      C_WIDGET:   k = 4'd0;
      C_GADGET:   k = 4'd1;
      C_WINDOW:   k = 4'd2;
      C_SCREEN:   k = 4'd3;
      C_GROUP:    k = 4'd4;
      C_MENUITEM: k = 4'd5;
      C_MENU:     k = 4'd6;
      C_MSGPORT:  k = 4'd7;
      C_MUTEX:    k = 4'd8;
      C_ROW, C_MODULE, C_DISPLAY, C_MSG: k = KIND_PASS;
      default:    k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic classes_match(input logic [3:0] ex, input logic [3:0] c);
    return (ex == c) || (ex == C_GENERIC) ||
           ((ex == C_WIDGET) && ((c == C_GADGET) || (c == C_WINDOW) || (c == C_SCREEN))) ||
           ((ex == C_ROW) && (c == C_MENUITEM));
  endfunction

endpackage

// ===== design/tha_req_if.sv =====
// ----------------------------------------------------------------------------
// tha_req_if: request channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface tha_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [3:0]  object_class;
  logic [9:0]  slot_index;
  logic [3:0]  expected_class;
  logic [31:0] object_handle;

  modport source (output valid, opcode, object_class, slot_index, expected_class,
                  object_handle, input ready);
  modport sink (input valid, opcode, object_class, slot_index, expected_class,
                object_handle, output ready);
endinterface

// ===== design/tha_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tha_rsp_if: response channel
// Valid/ready channel carrying one response word.
// ----------------------------------------------------------------------------
interface tha_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  result_class;
  logic [9:0]  result_index;
  logic [31:0] found_handle;

  modport source (output valid, status, result_class, result_index, found_handle,
                  input ready);
  modport sink (input valid, status, result_class, result_index, found_handle,
                output ready);
endinterface

// ===== design/tha_ram.sv =====
// ----------------------------------------------------------------------------
// tha_ram: generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module tha_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 9216
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== design/tha_ctrl.sv =====
// ----------------------------------------------------------------------------
// tha_ctrl: allocator controller
// Sequences dispatch, slot check and the up/down occupancy scans.
// ----------------------------------------------------------------------------
module tha_ctrl import tha_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = CMD_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = CMD_LOAD;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.assign_go) begin
          cmd_o.op = CMD_ASSIGN;
          state_d  = S_UP_RD;
        end else if (sts_i.need_read) begin
          cmd_o.op = CMD_READ_IDX;
          state_d  = S_CHECK;
        end else begin
          cmd_o.op = CMD_RES_IMM;
          state_d  = S_RESP;
        end
      end
      S_CHECK: begin
        cmd_o.op = CMD_CHECK;
        state_d  = (sts_i.is_drop && sts_i.drop_hit) ? S_DN_RD : S_RESP;
      end
      S_UP_RD: begin
        if (sts_i.ptr_ge_top) begin
          cmd_o.op = CMD_UP_DONE;
          state_d  = S_RESP;
        end else begin
          cmd_o.op = CMD_READ_PTR;
          state_d  = S_UP_CHK;
        end
      end
      S_UP_CHK: begin
        if (!sts_i.rd_occ) begin
          cmd_o.op = CMD_UP_DONE;
          state_d  = S_RESP;
        end else begin
          cmd_o.op = CMD_PTR_INC;
          state_d  = S_UP_RD;
        end
      end
      S_DN_RD: begin
        if (sts_i.ptr_le_lf) begin
          cmd_o.op = CMD_DN_BOT;
          state_d  = S_RESP;
        end else begin
          cmd_o.op = CMD_READ_PTR;
          state_d  = S_DN_CHK;
        end
      end
      S_DN_CHK: begin
        if (sts_i.rd_occ) begin
          cmd_o.op = CMD_DN_HIT;
          state_d  = S_RESP;
        end else begin
          cmd_o.op = CMD_PTR_DEC;
          state_d  = S_DN_RD;
        end
      end
      S_RESP: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = CMD_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== design/tha_dp.sv =====
// ----------------------------------------------------------------------------
// tha_dp: allocator datapath
// Request registers, per-table marks, slot RAM, scan pointer, response register.
// ----------------------------------------------------------------------------
module tha_dp import tha_pkg::*; #(
  parameter int CAPACITY    = 1024,
  parameter int HANDLE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  opcode_i,
  input  logic [3:0]  object_class_i,
  input  logic [9:0]  slot_index_i,
  input  logic [3:0]  expected_class_i,
  input  logic [31:0] object_handle_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [3:0]  result_class_o,
  output logic [9:0]  result_index_o,
  output logic [31:0] found_handle_o
);

  localparam int SB    = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
  localparam int PW    = $clog2(CAPACITY + 1);
  localparam int SW    = $clog2(CAPACITY);
  localparam int DEPTH = NUM_TABLES * CAPACITY;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = (PW > 10) ? PW : 10;

  logic [1:0]    op_q;
  logic [3:0]    cls_q, exp_q;
  logic [9:0]    idx_q;
  logic [SB-1:0] hdl_q;
  logic [PW-1:0] lf_q [NUM_TABLES];
  logic [PW-1:0] top_q [NUM_TABLES];
  logic [PW-1:0] ptr_q;
  logic [1:0]    res_st_q;
  logic [9:0]    res_idx_q;
  logic [SB-1:0] res_fnd_q;
  logic          out_valid_q;
  logic [1:0]    out_st_q;
  logic [3:0]    out_cls_q;
  logic [9:0]    out_idx_q;
  logic [SB-1:0] out_fnd_q;

  logic [3:0]    kind, tk;
  logic [PW-1:0] lf, top;
  logic          idx_lt_top;
  logic [1:0]    imm_st;
  logic [SW-1:0] slot;
  logic          we;
  logic [SB:0]   wdata, rdata;
  logic [AW-1:0] addr;

  assign kind       = class_kind(cls_q);
  assign tk         = (kind < 4'(NUM_TABLES)) ? kind : 4'd0;
  assign lf         = lf_q[tk];
  assign top        = top_q[tk];
  assign idx_lt_top = CW'(idx_q) < CW'(top);

  always_comb begin
    imm_st           = ST_NOTALLOW;
    sts_o.assign_go  = 1'b0;
    sts_o.need_read  = 1'b0;
    sts_o.is_drop    = (op_q == OP_DROP);
    sts_o.rd_occ     = rdata[SB];
    sts_o.drop_hit   = rdata[SB] && (rdata[SB-1:0] == hdl_q);
    sts_o.ptr_ge_top = ptr_q >= top;
    sts_o.ptr_le_lf  = ptr_q <= lf;
    sts_o.out_busy   = out_valid_q && !out_ready_i;
    case (op_q)
      OP_ASSIGN: begin
        if (kind == KIND_PASS) begin
          imm_st = ST_OK;
        end else if (kind != KIND_NONE) begin
          if (lf >= PW'(CAPACITY)) begin
            imm_st = ST_FULL;
          end else begin
            sts_o.assign_go = 1'b1;
          end
        end
      end
      OP_DROP: begin
        if (kind == KIND_PASS) begin
          imm_st = ST_OK;
        end else if (kind != KIND_NONE) begin
          imm_st          = ST_MISS;
          sts_o.need_read = idx_lt_top;
        end
      end
      OP_LOOKUP: begin
        if ((exp_q != C_UNDEF) && (cls_q != C_UNDEF)) begin
          imm_st          = ST_MISS;
          sts_o.need_read = classes_match(exp_q, cls_q) &&
                            (kind < 4'(NUM_TABLES)) && idx_lt_top;
        end
      end
      default: imm_st = ST_NOTALLOW;
    endcase
  end

  always_comb begin
    slot  = ptr_q[SW-1:0];
    we    = 1'b0;
    wdata = '0;
    case (cmd_i.op)
      CMD_ASSIGN: begin
        slot  = lf[SW-1:0];
        we    = 1'b1;
        wdata = {1'b1, hdl_q};
      end
      CMD_READ_IDX: slot = SW'(idx_q);
      CMD_CHECK: begin
        slot = SW'(idx_q);
        we   = sts_o.is_drop && sts_o.drop_hit;
      end
      default: slot = ptr_q[SW-1:0];
    endcase
  end

  assign addr = AW'(tk) * AW'(CAPACITY) + AW'(slot);

  tha_ram #(.WIDTH(SB + 1), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_LOAD: begin
        op_q  <= opcode_i;
        cls_q <= object_class_i;
        idx_q <= slot_index_i;
        exp_q <= expected_class_i;
        hdl_q <= object_handle_i[SB-1:0];
      end
      CMD_ASSIGN: begin
        ptr_q     <= lf + PW'(1);
        res_st_q  <= ST_OK;
        res_idx_q <= 10'(lf);
        res_fnd_q <= '0;
      end
      CMD_RES_IMM: begin
        res_st_q  <= imm_st;
        res_idx_q <= '0;
        res_fnd_q <= '0;
      end
      CMD_CHECK: begin
        ptr_q <= top - PW'(1);
        if (sts_o.is_drop) begin
          res_st_q  <= sts_o.drop_hit ? ST_OK : ST_MISS;
          res_idx_q <= idx_q;
          res_fnd_q <= '0;
        end else begin
          res_st_q  <= rdata[SB] ? ST_OK : ST_MISS;
          res_idx_q <= idx_q;
          res_fnd_q <= rdata[SB-1:0];
        end
      end
      CMD_PTR_INC: ptr_q <= ptr_q + PW'(1);
      CMD_PTR_DEC: ptr_q <= ptr_q - PW'(1);
      CMD_OUT: begin
        out_st_q  <= res_st_q;
        out_cls_q <= (res_st_q == ST_OK) ? cls_q : 4'd0;
        out_idx_q <= (res_st_q == ST_OK) ? res_idx_q : 10'd0;
        out_fnd_q <= (res_st_q == ST_OK) ? res_fnd_q : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int t = 0; t < NUM_TABLES; t++) begin
        lf_q[t]  <= '0;
        top_q[t] <= '0;
      end
    end else begin
      if (cmd_i.op == CMD_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        CMD_ASSIGN: begin
          if (top <= lf) begin
            top_q[tk] <= lf + PW'(1);
          end
        end
        CMD_CHECK: begin
          if (sts_o.is_drop && sts_o.drop_hit && (CW'(lf) > CW'(idx_q))) begin
            lf_q[tk] <= PW'(idx_q);
          end
        end
        CMD_UP_DONE: lf_q[tk]  <= ptr_q;
        CMD_DN_BOT:  top_q[tk] <= ptr_q;
        CMD_DN_HIT:  top_q[tk] <= ptr_q + PW'(1);
        default: ;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign result_class_o = out_cls_q;
  assign result_index_o = out_idx_q;
  assign found_handle_o = 32'(out_fnd_q);

endmodule

// ===== design/typed_handle_id_allocator.sv =====
// ----------------------------------------------------------------------------
// typed_handle_id_allocator: lowest-free id allocator with per-class tables
// Pass-through and refused words get their response without a slot read; a lookup
//   or a drop that passes its checks reads its slot. An assign writes the lowest
//   free slot, then scans up past occupied slots to a free slot or top; a drop hit
//   clears its slot, then scans down past free slots to an occupied slot or the free mark.
// One word in flight: the next word is taken in the cycle after the response is
//   loaded, later if the response waits. Reset clears the free and top marks
//   at once; slot RAM needs no clearing, only slots below top are ever read.
// ----------------------------------------------------------------------------
module typed_handle_id_allocator import tha_pkg::*; #(
  parameter int CAPACITY    = 1024,
  parameter int HANDLE_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tha_req_if.sink    req_i,
  tha_rsp_if.source  rsp_o
);

  cmd_t cmd;
  sts_t sts;

  tha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tha_dp #(.CAPACITY(CAPACITY), .HANDLE_BITS(HANDLE_BITS)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .opcode_i         (req_i.opcode),
    .object_class_i   (req_i.object_class),
    .slot_index_i     (req_i.slot_index),
    .expected_class_i (req_i.expected_class),
    .object_handle_i  (req_i.object_handle),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (rsp_o.valid),
    .out_ready_i      (rsp_o.ready),
    .status_o         (rsp_o.status),
    .result_class_o   (rsp_o.result_class),
    .result_index_o   (rsp_o.result_index),
    .found_handle_o   (rsp_o.found_handle)
  );

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for typed_handle_id_allocator
// Sends assign, drop and lookup words with random gaps on both channels.
// A scoreboard keeps its own copy of the per-class tables and checks every
// response word in order.
// ----------------------------------------------------------------------------
module tb;
  import tha_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 1024;
  localparam logic [1:0] OP_UNDEF = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  object_class;
    logic [9:0]  slot_index;
    logic [3:0]  expected_class;
    logic [31:0] object_handle;
  } req_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  result_class;
    logic [9:0]  result_index;
    logic [31:0] found_handle;
  } rsp_word_t;

  class alloc_scoreboard;
    bit [31:0] handles [NUM_TABLES][CAP];
    bit        used    [NUM_TABLES][CAP];
    int        lowest  [NUM_TABLES];
    int        top     [NUM_TABLES];
    rsp_word_t pending [$];
    int        errors;
    int        checked;
    int        st_count [4];

    function new();
      for (int t = 0; t < NUM_TABLES; t++) begin
        lowest[t] = 0;
        top[t] = 0;
        for (int i = 0; i < CAP; i++) begin
          handles[t][i] = '0;
          used[t][i] = 1'b0;
        end
      end
      errors = 0;
      checked = 0;
      for (int s = 0; s < 4; s++) st_count[s] = 0;
    endfunction

    // -1: no table, -2: pass-through, else table number
    function int table_of(logic [3:0] c);
      case (c)
        C_WIDGET:   return 0;
        C_GADGET:   return 1;
        C_WINDOW:   return 2;
        C_SCREEN:   return 3;
        C_GROUP:    return 4;
        C_MENUITEM: return 5;
        C_MENU:     return 6;
        C_MSGPORT:  return 7;
        C_MUTEX:    return 8;
        C_ROW, C_MODULE, C_DISPLAY, C_MSG: return -2;
        default:    return -1;
      endcase
    endfunction

    function bit compatible(logic [3:0] ex, logic [3:0] c);
      if (ex == c || ex == C_GENERIC) return 1'b1;
      if (ex == C_WIDGET && (c == C_GADGET || c == C_WINDOW || c == C_SCREEN)) return 1'b1;
      return ex == C_ROW && c == C_MENUITEM;
    endfunction

    function rsp_word_t apply(req_word_t w);
      rsp_word_t r;
      logic [1:0] st;
      int t;
      int id;
      int hi;
      int bot;
      int lo;
      int ix;
      st = ST_NOTALLOW;
      r = '0;
      t = table_of(w.object_class);
      ix = w.slot_index;
      if (w.opcode == OP_ASSIGN) begin
        if (t == -2) begin
          st = ST_OK;
        end else if (t >= 0) begin
          id = lowest[t];
          if (id >= CAP) begin
            st = ST_FULL;
          end else begin
            handles[t][id] = w.object_handle;
            used[t][id] = 1'b1;
            if (top[t] <= id) top[t] = id + 1;
            for (lo = id + 1; lo < top[t]; lo++)
              if (!used[t][lo]) break;
            lowest[t] = lo;
            st = ST_OK;
            r.result_index = 10'(id);
          end
        end
      end else if (w.opcode == OP_DROP) begin
        if (t == -2) begin
          st = ST_OK;
        end else if (t >= 0) begin
          st = ST_MISS;
          if (ix < top[t] && used[t][ix] && handles[t][ix] == w.object_handle) begin
            handles[t][ix] = '0;
            used[t][ix] = 1'b0;
            if (lowest[t] > ix) lowest[t] = ix;
            bot = lowest[t];
            for (hi = top[t] - 1; hi > bot; hi--)
              if (used[t][hi]) break;
            top[t] = (hi == bot) ? hi : hi + 1;
            st = ST_OK;
            r.result_index = 10'(ix);
          end
        end
      end else if (w.opcode == OP_LOOKUP) begin
        if (w.expected_class != C_UNDEF && w.object_class != C_UNDEF) begin
          st = ST_MISS;
          if (compatible(w.expected_class, w.object_class) && t >= 0) begin
            if (ix < top[t] && used[t][ix]) begin
              st = ST_OK;
              r.result_index = 10'(ix);
              r.found_handle = handles[t][ix];
            end
          end
        end
      end
      r.status = st;
      if (st == ST_OK) r.result_class = w.object_class;
      else r = '{status: st, default: '0};
      return r;
    endfunction

    function void note(req_word_t w);
      pending.push_back(apply(w));
    endfunction

    function void check(rsp_word_t got);
      rsp_word_t want;
      checked++;
      st_count[got.status]++;
      if (pending.size() == 0) begin
        $error("response word with nothing expected");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.result_class !== want.result_class) begin
        $error("result_class: expected %0d, got %0d", want.result_class, got.result_class);
        errors++;
      end
      if (got.result_index !== want.result_index) begin
        $error("result_index: expected %0d, got %0d", want.result_index, got.result_index);
        errors++;
      end
      if (got.found_handle !== want.found_handle) begin
        $error("found_handle: expected %h, got %h", want.found_handle, got.found_handle);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  tha_req_if req_if ();
  tha_rsp_if rsp_if ();

  typed_handle_id_allocator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  alloc_scoreboard sb;
  bit held_once;

  logic [3:0] table_classes [NUM_TABLES] = '{C_WIDGET, C_GADGET, C_WINDOW, C_SCREEN,
                                             C_GROUP, C_MENUITEM, C_MENU, C_MSGPORT, C_MUTEX};

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    #200_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic req_word_t make(logic [1:0] op, logic [3:0] c, logic [9:0] ix,
                                     logic [3:0] ex, logic [31:0] h);
    return '{opcode: op, object_class: c, slot_index: ix, expected_class: ex,
             object_handle: h};
  endfunction

  function automatic logic [31:0] rand_handle();
    return ($urandom_range(0, 15) == 0) ? 32'h0 : $urandom;
  endfunction

  task automatic send(req_word_t w);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.opcode         <= w.opcode;
    req_if.object_class   <= w.object_class;
    req_if.slot_index     <= w.slot_index;
    req_if.expected_class <= w.expected_class;
    req_if.object_handle  <= w.object_handle;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note(w);
  endtask

  task automatic receive_loop();
    int gap;
    rsp_word_t got;
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (!held_once && sb.checked >= 300) begin
        held_once = 1'b1;
        gap = 600;
      end
      @(negedge clk_i);
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      got = '{status: rsp_if.status, result_class: rsp_if.result_class,
              result_index: rsp_if.result_index, found_handle: rsp_if.found_handle};
      sb.check(got);
    end
  endtask

  task automatic random_word();
    int r;
    int t;
    int ix;
    logic [3:0] c;
    logic [3:0] ex;
    logic [31:0] h;
    r = $urandom_range(0, 99);
    t = $urandom_range(0, NUM_TABLES - 1);
    c = table_classes[t];
    h = rand_handle();
    ix = (sb.top[t] > 0) ? $urandom_range(0, sb.top[t] - 1) : 0;
    if (r < 35) begin
      send(make(OP_ASSIGN, c, 10'($urandom_range(0, 1023)), 4'($urandom_range(0, 15)), h));
    end else if (r < 60) begin
      if (sb.used[t][ix] && $urandom_range(0, 9) != 0) h = sb.handles[t][ix];
      send(make(OP_DROP, c, 10'(ix), 4'($urandom_range(0, 15)), h));
    end else if (r < 85) begin
      ex = $urandom_range(0, 1) ? c : 4'($urandom_range(0, 14));
      send(make(OP_LOOKUP, c, 10'(ix), ex, h));
    end else begin
      send(make(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                10'($urandom_range(0, 1023)), 4'($urandom_range(0, 15)), $urandom));
    end
  endtask

  initial begin
    sb = new();
    held_once = 1'b0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.opcode = OP_ASSIGN;
    req_if.object_class = C_GENERIC;
    req_if.slot_index = '0;
    req_if.expected_class = C_GENERIC;
    req_if.object_handle = '0;
    rsp_if.ready = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    fork
      receive_loop();
    join_none

    // every class code, handle extremes
    for (int c = 0; c < 16; c++)
      send(make(OP_ASSIGN, 4'(c), 10'h3ff, C_UNDEF, (c % 2) ? 32'hffff_ffff : 32'h0));
    send(make(OP_UNDEF, C_WIDGET, 10'h3ff, C_WIDGET, 32'hffff_ffff));
    send(make(OP_LOOKUP, C_WIDGET, 10'd0, C_UNDEF, 32'h0));
    send(make(OP_LOOKUP, C_UNDEF, 10'd0, C_GENERIC, 32'h0));
    send(make(OP_LOOKUP, C_GADGET, 10'd0, C_WIDGET, 32'h0));
    send(make(OP_LOOKUP, C_MENUITEM, 10'd0, C_ROW, 32'h0));
    send(make(OP_LOOKUP, C_GROUP, 10'd0, C_GENERIC, 32'h0));
    send(make(OP_LOOKUP, C_GROUP, 10'd0, C_MENU, 32'h0));
    send(make(OP_LOOKUP, C_MODULE, 10'd0, C_MODULE, 32'h0));
    send(make(OP_DROP, C_WIDGET, 10'd0, C_GENERIC, 32'h1234_5678));
    send(make(OP_DROP, C_WIDGET, 10'h3ff, C_GENERIC, 32'hffff_ffff));
    send(make(OP_DROP, C_ROW, 10'd5, C_GENERIC, 32'h0));
    send(make(OP_DROP, C_GENERIC, 10'd0, C_GENERIC, 32'h0));
    send(make(OP_DROP, C_GADGET, 10'd0, C_GENERIC, 32'h0));

    // fill one table to the last slot, then two assigns past full
    for (int i = 0; i <= CAP; i++)
      send(make(OP_ASSIGN, C_MUTEX, 10'($urandom_range(0, 1023)),
                4'($urandom_range(0, 15)), rand_handle()));

    for (int n = 0; n < 850; n++) random_word();

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Checked %0d response words over %0d table classes", sb.checked, NUM_TABLES);
    $display("  ok %0d, table full %0d, refused %0d, miss %0d",
             sb.st_count[ST_OK], sb.st_count[ST_FULL], sb.st_count[ST_NOTALLOW],
             sb.st_count[ST_MISS]);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tha_pkg.sv
design/tha_req_if.sv
design/tha_rsp_if.sv
design/tha_ram.sv
design/tha_ctrl.sv
design/tha_dp.sv
design/typed_handle_id_allocator.sv
test/tb.sv
